// ----- sv/tkfs_pkg.sv -----
// ----------------------------------------------------------------------------
// tkfs_pkg
// shared types and constants of the top-k largest file selector
// ----------------------------------------------------------------------------
`default_nettype none

package tkfs_pkg;

    localparam int KEY_W  = 64;
    localparam int IDX_W  = 32;
    localparam int RANK_W = 5;
    localparam int MODE_W = 2;
    localparam int TOPC_W = 6;
    localparam int CFG_W  = 2;

    // sort modes
    localparam logic [MODE_W-1:0] MODE_SIZE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COUNT = 2'd2;

    // register indexes
    localparam logic [CFG_W-1:0] CFG_SORT_MODE  = 2'd0;
    localparam logic [CFG_W-1:0] CFG_TOP_COUNT  = 2'd1;
    localparam logic [CFG_W-1:0] CFG_AGE_CUTOFF = 2'd2;
    localparam logic [CFG_W-1:0] CFG_MIN_SIZE   = 2'd3;

    localparam logic [TOPC_W-1:0] TOP_COUNT_RESET = 6'd20;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
    } t_link;

endpackage

`default_nettype wire

// ----- sv/tkfs_cell.sv -----
// ----------------------------------------------------------------------------
// tkfs_cell
// one slot of the sorted list: compares the broadcast key, shifts down on
// insert and up on readout
// ----------------------------------------------------------------------------
`default_nettype none

module tkfs_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_ins_en,
    input  wire logic                  i_shift,
    input  wire logic                  i_in_range,
    input  wire logic [63:0]           i_new_key,
    input  wire logic [31:0]           i_new_idx,
    input  wire tkfs_pkg::t_link       i_prev,
    input  wire logic                  i_prev_ins,
    input  wire tkfs_pkg::t_link       i_next,
    output tkfs_pkg::t_link            o_cell,
    output logic                       o_ins,
    output logic                       o_gt
);
    import tkfs_pkg::*;

    logic             r_valid;
    logic [KEY_W-1:0] r_key;
    logic [IDX_W-1:0] r_idx;
    logic             valid_eff;

    assign valid_eff = r_valid & i_in_range;
    assign o_ins     = i_ins_en & (!valid_eff | (i_new_key >= r_key));
    assign o_gt      = valid_eff & (i_new_key > r_key);
    assign o_cell    = '{valid: valid_eff, key: r_key, idx: r_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_step) begin
            if (!i_in_range) begin
                r_valid <= 1'b0;
            end else if (i_prev_ins) begin
                r_valid <= i_prev.valid;
            end else if (o_ins) begin
                r_valid <= 1'b1;
            end
        end else if (i_shift) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (i_prev_ins) begin
                r_key <= i_prev.key;
                r_idx <= i_prev.idx;
            end else if (o_ins) begin
                r_key <= i_new_key;
                r_idx <= i_new_idx;
            end
        end else if (i_shift) begin
            r_key <= i_next.key;
            r_idx <= i_next.idx;
        end
    end

endmodule

`default_nettype wire

// ----- sv/top_k_largest_file_selector.sv -----
// ----------------------------------------------------------------------------
// top_k_largest_file_selector
// keeps the best keys of a file record stream in a chain of sorted cells and
// reads them out in rank order on the last record
//
//   channel   signals                                   handshake
//   record    i_start, o_busy, i_entry_index .. i_is_last  start & !busy
//   result    o_valid, o_ranked_index .. o_final_item   one-cycle strobe
//   config    i_cfg_we, i_cfg_addr, i_cfg_wdata         write enable
//
// a record that is not last leaves busy low; a new one can follow at once
// a last record is inserted and then starts a readout of at least one result,
// one cell shifted toward the head per cycle, with busy high during the readout
// each result is registered and appears in the cycle after its readout cycle
// reset is synchronous and empties the list; results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_largest_file_selector #(
    parameter int MAX_TOP = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [31:0]                   i_entry_index,
    input  wire logic [63:0]                   i_file_size,
    input  wire logic [63:0]                   i_alloc_size,
    input  wire logic [63:0]                   i_mod_time,
    input  wire logic                          i_is_last,
    output logic                               o_valid,
    output logic [31:0]                        o_ranked_index,
    output logic [63:0]                        o_ranked_key,
    output logic [4:0]                         o_rank,
    output logic                               o_list_empty,
    output logic                               o_final_item,
    input  wire logic                          i_cfg_we,
    input  wire logic [tkfs_pkg::CFG_W-1:0]    i_cfg_addr,
    input  wire logic [63:0]                   i_cfg_wdata
);
    import tkfs_pkg::*;

    localparam int LIM_W = $clog2(MAX_TOP + 1);
    localparam int CW    = (LIM_W > TOPC_W) ? LIM_W : TOPC_W;

    typedef enum logic {ST_IDLE, ST_DRAIN} t_state;

    t_state              r_state;
    logic [MODE_W-1:0]   r_sort_mode;
    logic [TOPC_W-1:0]   r_top_count;
    logic [KEY_W-1:0]    r_age_cutoff;
    logic [KEY_W-1:0]    r_min_size;
    logic [RANK_W-1:0]   r_cnt;

    logic                accept;
    logic                pass;
    logic                skip;
    logic                ins_en;
    logic                shift;
    logic                full;
    logic                gt_tail;
    logic [KEY_W-1:0]    selected;
    logic [KEY_W-1:0]    new_key;
    logic [CW-1:0]       tc_eff;

    t_link               links   [MAX_TOP];
    logic [MAX_TOP-1:0]  ins;
    logic [MAX_TOP-1:0]  gt;
    logic [MAX_TOP-1:0]  valid_eff;
    logic [MAX_TOP-1:0]  in_range;
    logic [MAX_TOP-1:0]  tail;

    assign accept   = i_start && (r_state == ST_IDLE);
    assign o_busy   = (r_state == ST_DRAIN);
    assign shift    = (r_state == ST_DRAIN);
    assign selected = (r_sort_mode == MODE_ALLOC) ? i_alloc_size : i_file_size;
    assign new_key  = (r_sort_mode == MODE_COUNT) ? KEY_W'(1) : selected;
    assign pass     = !((r_age_cutoff != '0) && (i_mod_time >= r_age_cutoff))
                   && !((r_min_size != '0) && (selected < r_min_size));
    assign tc_eff   = (r_top_count == '0) ? CW'(1) : CW'(r_top_count);
    assign full     = |(valid_eff & tail);
    assign gt_tail  = |(gt & tail);
    assign skip     = full && !gt_tail;
    assign ins_en   = accept && pass && !skip;

    for (genvar g = 0; g < MAX_TOP; g++) begin : g_cell
        t_link prev_link;
        t_link next_link;
        logic  prev_ins;

        assign in_range[g]  = (CW'(g) < tc_eff);
        assign valid_eff[g] = links[g].valid;

        if (g == 0) begin : g_head
            assign prev_link = '0;
            assign prev_ins  = 1'b0;
        end else begin : g_body
            assign prev_link = links[g-1];
            assign prev_ins  = ins[g-1];
        end

        if (g == MAX_TOP - 1) begin : g_end
            assign next_link = '0;
            assign tail[g]   = in_range[g];
        end else begin : g_mid
            assign next_link = links[g+1];
            assign tail[g]   = in_range[g] & !in_range[g+1];
        end

        tkfs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_step     (accept),
            .i_ins_en   (ins_en),
            .i_shift    (shift),
            .i_in_range (in_range[g]),
            .i_new_key  (new_key),
            .i_new_idx  (i_entry_index),
            .i_prev     (prev_link),
            .i_prev_ins (prev_ins),
            .i_next     (next_link),
            .o_cell     (links[g]),
            .o_ins      (ins[g]),
            .o_gt       (gt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_mode  <= MODE_SIZE;
            r_top_count  <= TOP_COUNT_RESET;
            r_age_cutoff <= '0;
            r_min_size   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SORT_MODE:  r_sort_mode  <= i_cfg_wdata[MODE_W-1:0];
                CFG_TOP_COUNT:  r_top_count  <= i_cfg_wdata[TOPC_W-1:0];
                CFG_AGE_CUTOFF: r_age_cutoff <= i_cfg_wdata;
                CFG_MIN_SIZE:   r_min_size   <= i_cfg_wdata;
                default:        r_sort_mode  <= r_sort_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            o_valid        <= 1'b0;
            o_ranked_index <= '0;
            o_ranked_key   <= '0;
            o_rank         <= '0;
            o_list_empty   <= 1'b0;
            o_final_item   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (accept && i_is_last) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    o_valid <= 1'b1;
                    o_rank  <= r_cnt;
                    r_cnt   <= r_cnt + RANK_W'(1);
                    if (!links[0].valid) begin
                        o_ranked_index <= '0;
                        o_ranked_key   <= '0;
                        o_list_empty   <= 1'b1;
                        o_final_item   <= 1'b1;
                        r_state        <= ST_IDLE;
                    end else begin
                        o_ranked_index <= links[0].idx;
                        o_ranked_key   <= links[0].key;
                        o_list_empty   <= 1'b0;
                        o_final_item   <= (MAX_TOP == 1) ? 1'b1 : !valid_eff[MAX_TOP-1 > 0 ? 1 : 0];
                        if ((MAX_TOP == 1) || !valid_eff[MAX_TOP-1 > 0 ? 1 : 0]) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/tkfs_checker.sv -----
// ----------------------------------------------------------------------------
// tkfs_checker
// port-level checks of the readout sequence of the top-k file selector
// ----------------------------------------------------------------------------
`default_nettype none

module tkfs_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_is_last,
    input  wire logic        o_busy,
    input  wire logic        o_valid,
    input  wire logic [63:0] o_ranked_key,
    input  wire logic [31:0] o_ranked_index,
    input  wire logic [4:0]  o_rank,
    input  wire logic        o_list_empty,
    input  wire logic        o_final_item
);

    // a last record always starts a readout
    a_last_starts_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_is_last |=> o_busy)
        else $error("last record did not start a readout");

    // results only come out of a readout
    a_result_from_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result outside a readout");

    // the final result ends the readout, others keep it going
    a_final_ends_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_final_item == !o_busy))
        else $error("readout end does not match final marker");

    // ranks run without gaps
    a_rank_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_final_item |=> o_valid && (o_rank == $past(o_rank) + 5'd1))
        else $error("rank sequence broken");

    // the empty marker is a lone zero result
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_list_empty |-> o_final_item && (o_rank == 5'd0)
            && (o_ranked_key == 64'd0) && (o_ranked_index == 32'd0))
        else $error("malformed empty marker");

endmodule

bind top_k_largest_file_selector tkfs_checker u_tkfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .i_is_last      (i_is_last),
    .o_busy         (o_busy),
    .o_valid        (o_valid),
    .o_ranked_key   (o_ranked_key),
    .o_ranked_index (o_ranked_index),
    .o_rank         (o_rank),
    .o_list_empty   (o_list_empty),
    .o_final_item   (o_final_item)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the top-k largest file selector
//
// record transactions are driven on the falling edge and predicted at the
// rising edge where they are accepted. A model of the sorted list in the
// bench works out the ranked readout that each last record causes. Every
// result strobe is compared field by field with the oldest expected entry.
// The stimulus opens with short directed lists: rank order, ties, a full
// list, the filters, all sort modes and a shrunken top count. It then runs
// random lists under random register settings, with random gaps on the
// record side.
// ----------------------------------------------------------------------------
module tb_top;
    import tkfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LIST_DEPTH     = 32;
    localparam int RANDOM_RECORDS = 450;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] fsize;
        logic [KEY_W-1:0] asize;
        logic [KEY_W-1:0] mtime;
        logic             last;
    } t_file_rec;

    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic              empty;
        logic              final_item;
    } t_ranked;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [31:0]          i_entry_index;
    logic [63:0]          i_file_size;
    logic [63:0]          i_alloc_size;
    logic [63:0]          i_mod_time;
    logic                 i_is_last;
    logic                 o_valid;
    logic [31:0]          o_ranked_index;
    logic [63:0]          o_ranked_key;
    logic [4:0]           o_rank;
    logic                 o_list_empty;
    logic                 o_final_item;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_addr;
    logic [63:0]          i_cfg_wdata;

    // bench copy of the list and the registers
    logic [KEY_W-1:0]  kept_keys [LIST_DEPTH];
    logic [IDX_W-1:0]  kept_ids  [LIST_DEPTH];
    int                kept_count;
    logic [MODE_W-1:0] cur_mode;
    logic [TOPC_W-1:0] cur_top;
    logic [KEY_W-1:0]  cur_age;
    logic [KEY_W-1:0]  cur_min;

    t_ranked expected_ranks[$];
    int      mismatch_count;
    int      records_sent;
    int      readouts;
    int      results_seen;
    int      stall_cycles;

    top_k_largest_file_selector #(
        .MAX_TOP(LIST_DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_entry_index  (i_entry_index),
        .i_file_size    (i_file_size),
        .i_alloc_size   (i_alloc_size),
        .i_mod_time     (i_mod_time),
        .i_is_last      (i_is_last),
        .o_valid        (o_valid),
        .o_ranked_index (o_ranked_index),
        .o_ranked_key   (o_ranked_key),
        .o_rank         (o_rank),
        .o_list_empty   (o_list_empty),
        .o_final_item   (o_final_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic void predict_ranking(t_file_rec r);
        int               lim;
        int               pos;
        int               i;
        logic [KEY_W-1:0] sel;
        logic [KEY_W-1:0] key;
        bit               pass;
        t_ranked          e;
        lim = (cur_top == 0) ? 1 : (cur_top > LIST_DEPTH) ? LIST_DEPTH : int'(cur_top);
        if (kept_count > lim) kept_count = lim;
        sel  = (cur_mode == MODE_ALLOC) ? r.asize : r.fsize;
        pass = !((cur_age != 0 && r.mtime >= cur_age) || (cur_min != 0 && sel < cur_min));
        key  = (cur_mode == MODE_COUNT) ? 64'd1 : sel;
        if (pass && !(kept_count >= lim && key <= kept_keys[lim-1])) begin
            pos = 0;
            while (pos < kept_count && kept_keys[pos] > key) pos++;
            i = (kept_count < lim) ? kept_count : lim - 1;
            while (i > pos) begin
                kept_keys[i] = kept_keys[i-1];
                kept_ids[i]  = kept_ids[i-1];
                i--;
            end
            kept_keys[pos] = key;
            kept_ids[pos]  = r.idx;
            if (kept_count < lim) kept_count++;
        end
        if (r.last) begin
            if (kept_count == 0) begin
                e = '{idx: '0, key: '0, rank: '0, empty: 1'b1, final_item: 1'b1};
                expected_ranks = {expected_ranks, e};
            end
            for (i = 0; i < kept_count; i++) begin
                e.idx        = kept_ids[i];
                e.key        = kept_keys[i];
                e.rank       = i[RANK_W-1:0];
                e.empty      = 1'b0;
                e.final_item = (i == kept_count - 1);
                expected_ranks = {expected_ranks, e};
            end
            kept_count = 0;
            readouts++;
        end
    endfunction

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_ranked want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_ranks.size() == 0) begin
                $error("result with no transaction expected: index %0h key %0h",
                       o_ranked_index, o_ranked_key);
                mismatch_count++;
            end else begin
                want = expected_ranks.pop_front();
                check_field("ranked_index", 64'(want.idx), 64'(o_ranked_index));
                check_field("ranked_key", want.key, o_ranked_key);
                check_field("rank", 64'(want.rank), 64'(o_rank));
                check_field("list_empty", 64'(want.empty), 64'(o_list_empty));
                check_field("final_item", 64'(want.final_item), 64'(o_final_item));
            end
        end
    end

    // counts cycles in which no transaction moves on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return '1;
            2, 3:    return 64'($urandom_range(0, 15));
            4:       return 64'd1 << $urandom_range(0, 63);
            default: return rand64();
        endcase
    endfunction

    function automatic t_file_rec mk_rec(logic [31:0] idx, logic [63:0] fsize,
                                         logic [63:0] asize, logic [63:0] mtime, logic last);
        t_file_rec r;
        r.idx   = idx;
        r.fsize = fsize;
        r.asize = asize;
        r.mtime = mtime;
        r.last  = last;
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic int pick_len();
        int p;
        p = $urandom_range(0, 9);
        if (p < 7) return $urandom_range(1, 10);
        if (p < 9) return $urandom_range(11, 24);
        return $urandom_range(25, 45);
    endfunction

    function automatic logic [TOPC_W-1:0] pick_top();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return TOPC_W'(LIST_DEPTH);
            3:       return TOPC_W'(1);
            4:       return TOPC_W'($urandom_range(33, 62));
            default: return TOPC_W'($urandom_range(2, 31));
        endcase
    endfunction

    // all tasks below start and end at a falling edge
    task automatic send_record(input t_file_rec r);
        i_entry_index = r.idx;
        i_file_size   = r.fsize;
        i_alloc_size  = r.asize;
        i_mod_time    = r.mtime;
        i_is_last     = r.last;
        i_start       = 1'b1;
        do @(posedge i_clk); while (o_busy);
        predict_ranking(r);
        records_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        if (n > 0) begin
            i_start       = 1'b0;
            i_entry_index = $urandom;
            i_file_size   = rand64();
            i_alloc_size  = rand64();
            i_mod_time    = rand64();
            i_is_last     = $urandom_range(0, 1);
            repeat (n) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_start = 1'b0;
        while (expected_ranks.size() != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] addr, input logic [63:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = data;
        case (addr)
            CFG_SORT_MODE:  cur_mode = data[MODE_W-1:0];
            CFG_TOP_COUNT:  cur_top  = data[TOPC_W-1:0];
            CFG_AGE_CUTOFF: cur_age  = data;
            CFG_MIN_SIZE:   cur_min  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        logic [63:0] data;
        data = rand64();
        data[MODE_W-1:0] = mode;
        write_reg(CFG_SORT_MODE, data);
    endtask

    task automatic write_top(input logic [TOPC_W-1:0] top);
        logic [63:0] data;
        data = rand64();
        data[TOPC_W-1:0] = top;
        write_reg(CFG_TOP_COUNT, data);
    endtask

    task automatic test_reset_defaults();
        send_record(mk_rec(32'd10, 64'd100, 64'd0, '1, 1'b0));
        send_record(mk_rec(32'd11, 64'd0, '1, 64'd0, 1'b0));
        send_record(mk_rec(32'd12, 64'd100, 64'd3, 64'd9, 1'b1));
    endtask

    task automatic test_rank_order();
        wait_idle();
        write_mode(MODE_SIZE);
        write_top(TOPC_W'(3));
        write_reg(CFG_AGE_CUTOFF, 64'd0);
        write_reg(CFG_MIN_SIZE, 64'd0);
        send_record(mk_rec(32'd0, 64'd5, rand64(), rand64(), 1'b0));
        send_record(mk_rec('1, '1, rand64(), '1, 1'b0));
        send_record(mk_rec(32'd1, 64'd5, rand64(), rand64(), 1'b0));
        // list full: at or below the worst key is skipped
        send_record(mk_rec(32'd2, 64'd0, rand64(), rand64(), 1'b0));
        send_record(mk_rec(32'd3, 64'd5, rand64(), rand64(), 1'b0));
        send_record(mk_rec(32'd4, 64'd7, rand64(), rand64(), 1'b1));
    endtask

    task automatic test_filters();
        wait_idle();
        write_mode(MODE_ALLOC);
        write_top(TOPC_W'(8));
        write_reg(CFG_AGE_CUTOFF, 64'd100);
        write_reg(CFG_MIN_SIZE, 64'd50);
        send_record(mk_rec(32'd20, 64'd0, 64'd50, 64'd99, 1'b0));
        send_record(mk_rec(32'd21, 64'd1000, 64'd60, 64'd100, 1'b0));
        send_record(mk_rec(32'd22, 64'd1000, 64'd49, 64'd0, 1'b0));
        send_record(mk_rec(32'd23, 64'd0, '1, 64'd0, 1'b1));
        // nothing qualifies: empty marker
        send_record(mk_rec(32'd24, 64'd0, 64'd10, 64'd5, 1'b1));
        wait_idle();
        write_mode(MODE_SIZE);
        write_reg(CFG_AGE_CUTOFF, '1);
        write_reg(CFG_MIN_SIZE, '1);
        send_record(mk_rec(32'd25, '1, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1));
    endtask

    task automatic test_sort_modes();
        wait_idle();
        write_mode(MODE_COUNT);
        write_top(TOPC_W'(2));
        write_reg(CFG_AGE_CUTOFF, 64'd0);
        write_reg(CFG_MIN_SIZE, 64'd0);
        send_record(mk_rec(32'd30, rand64(), rand64(), rand64(), 1'b0));
        send_record(mk_rec(32'd31, rand64(), rand64(), rand64(), 1'b0));
        send_record(mk_rec(32'd32, rand64(), rand64(), rand64(), 1'b0));
        send_record(mk_rec(32'd33, rand64(), rand64(), rand64(), 1'b1));
        // unused mode ranks by file size; top count saturates
        wait_idle();
        write_mode(2'd3);
        write_top('1);
        send_record(mk_rec(32'd40, 64'd7, 64'd9, rand64(), 1'b0));
        send_record(mk_rec(32'd41, 64'd8, 64'd1, rand64(), 1'b1));
    endtask

    task automatic test_shrink_list();
        int k;
        wait_idle();
        write_mode(MODE_SIZE);
        write_top(TOPC_W'(6));
        for (k = 1; k <= 5; k++)
            send_record(mk_rec(32'(50 + k), 64'(k), rand64(), rand64(), 1'b0));
        wait_idle();
        write_top(TOPC_W'(2));
        send_record(mk_rec(32'd56, 64'd3, rand64(), rand64(), 1'b1));
    endtask

    task automatic randomize_config();
        if ($urandom_range(0, 1)) write_mode(MODE_W'($urandom_range(0, 3)));
        if ($urandom_range(0, 1)) write_top(pick_top());
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: write_reg(CFG_AGE_CUTOFF, 64'd0);
                3:       write_reg(CFG_AGE_CUTOFF, '1);
                4:       write_reg(CFG_AGE_CUTOFF, rand64());
                default: write_reg(CFG_AGE_CUTOFF, 64'($urandom_range(1, 16)));
            endcase
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0, 1, 2: write_reg(CFG_MIN_SIZE, 64'd0);
                3:       write_reg(CFG_MIN_SIZE, rand64());
                4:       write_reg(CFG_MIN_SIZE, 64'd1);
                default: write_reg(CFG_MIN_SIZE, '1);
            endcase
        end
    endtask

    task automatic test_random_streams();
        int        sent;
        int        phase_len;
        int        split;
        int        k;
        bit        gap_free;
        t_file_rec r;
        sent = 0;
        while (sent < RANDOM_RECORDS) begin
            wait_idle();
            randomize_config();
            phase_len = pick_len();
            gap_free  = ($urandom_range(0, 3) == 0);
            split     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, phase_len) : -1;
            for (k = 0; k < phase_len; k++) begin
                if (k == split) begin
                    // change the list size while entries are held
                    wait_idle();
                    write_top(pick_top());
                end
                r = mk_rec($urandom, pick_value(), pick_value(), pick_value(),
                           k == phase_len - 1);
                send_record(r);
                sent++;
                if (!gap_free) idle_gap(pick_gap());
            end
        end
    endtask

    initial begin
        mismatch_count = 0;
        records_sent   = 0;
        readouts       = 0;
        results_seen   = 0;
        kept_count     = 0;
        cur_mode       = MODE_SIZE;
        cur_top        = TOP_COUNT_RESET;
        cur_age        = '0;
        cur_min        = '0;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_entry_index  = '0;
        i_file_size    = '0;
        i_alloc_size   = '0;
        i_mod_time     = '0;
        i_is_last      = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_SORT_MODE;
        i_cfg_wdata    = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_rank_order();
        test_filters();
        test_sort_modes();
        test_shrink_list();
        test_random_streams();

        i_start = 1'b0;
        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (expected_ranks.size() != 0) begin
            $error("%0d expected results never arrived", expected_ranks.size());
            mismatch_count++;
        end
        $display("%0d records sent, %0d list readouts, %0d ranked results checked",
                 records_sent, readouts, results_seen);
        $display("covered ties, full lists, filters, all sort modes and top count limits");
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
